@@ src/lru_pkg.sv @@
// package for the recency list manager: sizes, operation codes
package lru_pkg;
    localparam int POOL_ENTRIES = 1024;
    localparam int HW = $clog2(POOL_ENTRIES);
    localparam int DW = 32;
    localparam int CW = $clog2(POOL_ENTRIES);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_TOUCH  = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;

    typedef logic [HW-1:0] handle_t;
endpackage

@@ src/lru_list_manager.sv @@
// recency list manager top level: linked list in synchronous memories
//
// Keeps a doubly linked recency list of (slab id, slab offset) pairs in a
// pool of POOL_ENTRIES entries; handle 0 is null. Insert links a free entry
// at the oldest end (full_res when none is free), touch moves an entry to
// the newest end, erase unlinks and frees it. Each word in gives one word
// out, which also carries the pair at the oldest end. Links, payload and
// the free stack live in synchronous memories (links with separate read and
// write addresses, the rest single-port), so an item is sequenced through
// read and write steps after the cycle that accepts it. Touch adds an
// append step; touch skips its link steps when nothing moves, erase when
// the handle is not live, and a full insert or an unused kind skips them
// all. After reset a clearing pass fills the free stack and clears the live
// bit memory; no word is taken during that pass. The result sits in an
// output register, so the next word is accepted while the previous result
// still waits; a new result that is ready while the previous one is still
// stalled holds in its last step until the output register frees.
module lru_list_manager
    import lru_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    kind,
    input  logic [31:0]   slab_id,
    input  logic [31:0]   slab_offset,
    input  logic [9:0]    handle,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [9:0]    new_handle,
    output logic          full_res,
    output logic          oldest_valid,
    output logic [31:0]   oldest_slab_id,
    output logic [31:0]   oldest_slab_offset
);
    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;  // read own links / free stack top
    localparam logic [3:0] S_OP1  = 4'd3;  // data arrives
    localparam logic [3:0] S_OP2  = 4'd4;
    localparam logic [3:0] S_OP3  = 4'd5;
    localparam logic [3:0] S_OLD  = 4'd6;  // read oldest payload
    localparam logic [3:0] S_OLDW = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // memories
    logic [HW-1:0] next_mem [POOL_ENTRIES];
    logic [HW-1:0] prev_mem [POOL_ENTRIES];
    logic [DW-1:0] sid_mem  [POOL_ENTRIES];
    logic [DW-1:0] soff_mem [POOL_ENTRIES];
    logic          live_mem [POOL_ENTRIES];
    logic [HW-1:0] free_mem [POOL_ENTRIES];

    logic [3:0]    state_reg;
    logic [CW-1:0] init_reg;
    logic [1:0]    kind_reg;
    logic [DW-1:0] sid_reg, soff_reg;
    handle_t       h_reg, nx_reg, pv_reg;
    handle_t       oldest_reg, newest_reg;
    logic [CW-1:0] free_count_reg;
    logic          full_pend_reg;
    logic          out_valid_reg;
    logic [9:0]    new_handle_reg;
    logic          full_reg;
    logic          ovalid_reg;
    logic [DW-1:0] osid_reg, osoff_reg;

    // registered read data
    handle_t       next_rd, prev_rd, free_rd;
    logic [DW-1:0] sid_rd, soff_rd;
    logic          live_rd;

    // memory port controls
    logic          next_we, prev_we, live_we, free_we, pay_we;
    handle_t       next_wa, prev_wa, next_ra, prev_ra, live_a, pay_a;
    handle_t       next_wd, prev_wd;
    logic          live_wd;
    logic [CW-1:0] free_a;
    handle_t       free_wd;

    logic usable;
    assign usable = (h_reg != '0) && live_rd;

    always_ff @(posedge clk)
    begin
        if (next_we) next_mem[next_wa] <= next_wd;
        next_rd <= next_mem[next_ra];
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        prev_rd <= prev_mem[prev_ra];
        if (live_we) live_mem[live_a] <= live_wd;
        live_rd <= live_mem[live_a];
        if (free_we) free_mem[free_a] <= free_wd;
        free_rd <= free_mem[free_a];
        if (pay_we)
        begin
            sid_mem[pay_a]  <= sid_reg;
            soff_mem[pay_a] <= soff_reg;
        end
        sid_rd  <= sid_mem[pay_a];
        soff_rd <= soff_mem[pay_a];
    end

    always_comb
    begin
        next_we = 1'b0; prev_we = 1'b0; live_we = 1'b0; free_we = 1'b0;
        pay_we = 1'b0;
        next_wa = h_reg; prev_wa = h_reg; next_ra = h_reg; prev_ra = h_reg;
        live_a = h_reg; pay_a = oldest_reg;
        next_wd = '0; prev_wd = '0; live_wd = 1'b0;
        free_a = free_count_reg - 1'b1; free_wd = h_reg;
        case (state_reg)
            S_INIT:
            begin
                live_we = 1'b1;
                live_a  = init_reg[HW-1:0];
                free_we = 1'b1;
                free_a  = init_reg;
                free_wd = handle_t'(CW'(POOL_ENTRIES - 1) - init_reg);
            end
            S_OP1:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    // h_reg is not yet known: free_rd holds it
                    live_we = 1'b1; live_wd = 1'b1; live_a = free_rd;
                    pay_we = 1'b1; pay_a = free_rd;
                    prev_we = 1'b1; prev_wa = free_rd; prev_wd = '0;
                    next_we = 1'b1; next_wa = free_rd; next_wd = oldest_reg;
                end
                else if (kind_reg == KIND_ERASE && usable)
                begin
                    live_we = 1'b1; live_wd = 1'b0;
                    free_a  = free_count_reg;
                    free_we = (free_count_reg != CW'(POOL_ENTRIES - 1));
                end
            end
            S_OP2:
            begin
                // oldest_reg still the old head for insert
                if (kind_reg == KIND_INSERT)
                begin
                    prev_we = (oldest_reg != '0); prev_wa = oldest_reg; prev_wd = h_reg;
                end
                else
                begin
                    // unlink: pv.next = nx, nx.prev = pv
                    next_we = (pv_reg != '0); next_wa = pv_reg; next_wd = nx_reg;
                    prev_we = (nx_reg != '0); prev_wa = nx_reg; prev_wd = pv_reg;
                end
            end
            S_OP3:
            begin
                // touch: append at newest end
                next_we = 1'b1; next_wa = newest_reg; next_wd = h_reg;
                prev_we = 1'b1; prev_wa = h_reg;      prev_wd = newest_reg;
            end
            S_OLDW:
            begin
                // touch: clear own next (after newest write, which may alias pv)
                next_we = (kind_reg == KIND_TOUCH); next_wa = h_reg; next_wd = '0;
            end
            default: ;
        endcase
    end

    assign in_stall     = (state_reg != S_IDLE) && (state_reg != S_OUT);
    assign out_valid    = out_valid_reg;
    assign new_handle   = new_handle_reg;
    assign full_res     = full_reg;
    assign oldest_valid = ovalid_reg;
    assign oldest_slab_id     = osid_reg;
    assign oldest_slab_offset = osoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_reg       <= '0;
            oldest_reg     <= '0;
            newest_reg     <= '0;
            free_count_reg <= CW'(POOL_ENTRIES - 1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OLDW)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == CW'(POOL_ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE, S_OUT:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind;
                        sid_reg   <= slab_id;
                        soff_reg  <= slab_offset;
                        h_reg     <= handle;
                        state_reg <= S_RD1;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_RD1:
                begin
                    full_pend_reg <= 1'b0;
                    if (kind_reg == KIND_INSERT && free_count_reg == '0)
                    begin
                        full_pend_reg <= 1'b1;
                        state_reg     <= S_OLD;
                    end
                    else if (kind_reg == KIND_INSERT || kind_reg == KIND_TOUCH
                             || kind_reg == KIND_ERASE)
                        state_reg <= S_OP1;
                    else
                        state_reg <= S_OLD;
                end
                S_OP1:
                begin
                    nx_reg <= next_rd;
                    pv_reg <= prev_rd;
                    state_reg <= S_OLD;
                    if (kind_reg == KIND_INSERT)
                    begin
                        h_reg          <= free_rd;
                        free_count_reg <= free_count_reg - 1'b1;
                        state_reg      <= S_OP2;
                    end
                    else if (usable && kind_reg == KIND_ERASE)
                    begin
                        if (free_count_reg != CW'(POOL_ENTRIES - 1))
                            free_count_reg <= free_count_reg + 1'b1;
                        state_reg <= S_OP2;
                    end
                    else if (usable && next_rd != '0)
                        state_reg <= S_OP2;
                end
                S_OP2:
                begin
                    state_reg <= S_OLD;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (oldest_reg == '0)
                            newest_reg <= h_reg;
                        oldest_reg <= h_reg;
                    end
                    else
                    begin
                        if (pv_reg == '0)
                            oldest_reg <= nx_reg;
                        if (kind_reg == KIND_ERASE && nx_reg == '0)
                            newest_reg <= pv_reg;
                        if (kind_reg == KIND_TOUCH)
                            state_reg <= S_OP3;
                    end
                end
                S_OP3:
                begin
                    newest_reg <= h_reg;
                    state_reg  <= S_OLD;
                end
                S_OLD:
                    state_reg <= S_OLDW;
                S_OLDW:
                begin
                    // previous word still waiting: hold here
                    if (out_valid_reg && out_stall)
                        state_reg <= S_OLDW;
                    else
                    begin
                        new_handle_reg <= (kind_reg == KIND_INSERT && !full_pend_reg)
                                          ? h_reg : '0;
                        full_reg      <= full_pend_reg;
                        ovalid_reg    <= (oldest_reg != '0);
                        osid_reg      <= (oldest_reg != '0) ? sid_rd  : '0;
                        osoff_reg     <= (oldest_reg != '0) ? soff_rd : '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
